/* design/mfqs_pkg.sv */
// Package for the multilevel feedback queue scheduler.
// Holds sizes, register indexes, the record type, controller states and the
// command/status structs shared by the controller, datapath and top level.
package mfqs_pkg;

  // Scheduler sizing
  localparam int NUM_LEVELS = 3;
  localparam int MAX_TASKS  = 16;

  localparam int TASK_W     = 4;                          // task id width
  localparam int LVL_W      = $clog2(NUM_LEVELS);         // level width
  localparam int CNT_W      = $clog2(MAX_TASKS + 1);      // fifo fill width
  localparam int FIFO_DEPTH = NUM_LEVELS * MAX_TASKS;     // all level fifos
  localparam int FIFO_AW    = LVL_W + TASK_W;             // {level, slot}

  // Configuration register defaults
  localparam logic [15:0] QUANTUM_RESET = 16'd500;
  localparam logic [15:0] TICK_RESET    = 16'd10;

  // Register indexes (byte address bit 2)
  localparam logic REG_QUANTUM = 1'b0;
  localparam logic REG_TICK    = 1'b1;

  // Item modes
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  // Per-task timing record
  typedef struct packed {
    logic [15:0] quantum_used;
    logic [31:0] elapsed;
    logic [31:0] burst;
  } rec_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARR,
    ST_UPD,
    ST_PICK,
    ST_POP,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // latch word, start record read
    logic arr;       // handle arrival
    logic upd;       // credit tick to running task
    logic pick;      // choose level, read fifo head
    logic pop;       // dispatch the fifo head
    logic load_out;  // load result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mode;      // latched word is a tick
    logic cpu_busy;  // a task holds the CPU
    logic frees;     // running task leaves the CPU in this update
    logic nonempty;  // some level fifo holds a task
    logic out_free;  // result register can take a word
  } dp_sts_t;

endpackage

/* design/mfqs_ctrl.sv */
// Controller state machine of the feedback queue scheduler.
// Sequences arrival, tick update, dispatch and result load; uses mfqs_pkg.
module mfqs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mfqs_pkg::dp_sts_t  sts,
  output mfqs_pkg::dp_cmd_t  cmd
);
  import mfqs_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_ARR;
        end
      end
      ST_ARR: begin
        // decide path on the latched word
        if (sts.mode == MODE_TICK) begin
          state_nxt = sts.cpu_busy ? ST_UPD : ST_PICK;
        end else begin
          cmd.arr   = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.frees ? ST_PICK : ST_OUT;
      end
      ST_PICK: begin
        cmd.pick  = sts.nonempty;
        state_nxt = sts.nonempty ? ST_POP : ST_OUT;
      end
      ST_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/mfqs_dp.sv */
// Datapath of the feedback queue scheduler: task flags, record memory,
// level fifo memory, CPU state and result register. Uses mfqs_pkg.
module mfqs_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  mfqs_pkg::dp_cmd_t  cmd,
  output mfqs_pkg::dp_sts_t  sts,
  input  logic [15:0]        quantum_ms,
  input  logic [15:0]        tick_ms,
  input  logic               in_mode,
  input  logic [3:0]         in_task_id,
  input  logic [31:0]        in_burst_ms,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic               out_done_valid,
  output logic [3:0]         out_done_task,
  output logic [31:0]        out_done_time_ms,
  output logic               out_running_valid,
  output logic [3:0]         out_running_task,
  output logic [1:0]         out_running_level
);
  import mfqs_pkg::*;

  // Memories
  rec_t              rec_mem  [MAX_TASKS];
  logic [TASK_W-1:0] fifo_mem [FIFO_DEPTH];
  rec_t              rec_rd_r;
  logic [TASK_W-1:0] fifo_rd_r;

  // Latched word
  logic              mode_r, mode_nxt;
  logic [TASK_W-1:0] id_r, id_nxt;
  logic [31:0]       burst_r, burst_nxt;
  logic [31:0]       now_r, now_nxt;

  // Task flags and levels
  logic [MAX_TASKS-1:0] rec_valid_r, rec_valid_nxt;
  logic [MAX_TASKS-1:0] active_r, active_nxt;
  logic [LVL_W-1:0]     task_level_r [MAX_TASKS];
  logic [LVL_W-1:0]     task_level_nxt [MAX_TASKS];

  // Level fifo pointers
  logic [TASK_W-1:0] head_r [NUM_LEVELS];
  logic [TASK_W-1:0] head_nxt [NUM_LEVELS];
  logic [CNT_W-1:0]  count_r [NUM_LEVELS];
  logic [CNT_W-1:0]  count_nxt [NUM_LEVELS];

  // CPU state
  logic              cpu_busy_r, cpu_busy_nxt;
  logic [TASK_W-1:0] cpu_task_r, cpu_task_nxt;
  logic [LVL_W-1:0]  cpu_level_r, cpu_level_nxt;
  logic [LVL_W-1:0]  pick_lvl_r, pick_lvl_nxt;

  // Per-item results
  logic              status_r, status_nxt;
  logic              done_valid_r, done_valid_nxt;
  logic [TASK_W-1:0] done_task_r, done_task_nxt;
  logic [31:0]       done_time_r, done_time_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic              o_status_r, o_status_nxt;
  logic              o_done_valid_r, o_done_valid_nxt;
  logic [3:0]        o_done_task_r, o_done_task_nxt;
  logic [31:0]       o_done_time_r, o_done_time_nxt;
  logic              o_run_valid_r, o_run_valid_nxt;
  logic [3:0]        o_run_task_r, o_run_task_nxt;
  logic [1:0]        o_run_level_r, o_run_level_nxt;

  // Combinational helpers
  logic              push_en, push_ok;
  logic [LVL_W-1:0]  push_lvl;
  logic [TASK_W-1:0] push_id;
  logic [FIFO_AW-1:0] fifo_wa;
  logic              rec_we;
  rec_t              rec_wd;
  logic [TASK_W-1:0] rec_wa;
  logic [32:0]       e_sum;
  logic [31:0]       e_sat;
  logic [16:0]       q_sum;
  logic [15:0]       q_sat;
  logic              upd_done, upd_demote;
  logic [LVL_W-1:0]  demote_lvl;
  logic [LVL_W-1:0]  pick_lvl;
  logic              nonempty;

  // Tick arithmetic, saturating
  always_comb begin
    e_sum      = {1'b0, rec_rd_r.elapsed} + {17'b0, tick_ms};
    e_sat      = e_sum[32] ? 32'hFFFF_FFFF : e_sum[31:0];
    q_sum      = {1'b0, rec_rd_r.quantum_used} + {1'b0, tick_ms};
    q_sat      = q_sum[16] ? 16'hFFFF : q_sum[15:0];
    upd_done   = (e_sat >= rec_rd_r.burst);
    upd_demote = !upd_done && (q_sat >= quantum_ms);
    demote_lvl = (cpu_level_r < LVL_W'(NUM_LEVELS - 1)) ? cpu_level_r + 1'b1 : cpu_level_r;
  end

  // Highest-priority non-empty level (lowest index, level 0 first)
  always_comb begin
    pick_lvl = '0;
    nonempty = 1'b0;
    for (int lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
      if (count_r[lv] != '0) begin
        pick_lvl = LVL_W'(lv);
        nonempty = 1'b1;
      end
    end
  end

  // Next state of the datapath
  always_comb begin
    mode_nxt       = mode_r;
    id_nxt         = id_r;
    burst_nxt      = burst_r;
    now_nxt        = now_r;
    rec_valid_nxt  = rec_valid_r;
    active_nxt     = active_r;
    task_level_nxt = task_level_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    cpu_busy_nxt   = cpu_busy_r;
    cpu_task_nxt   = cpu_task_r;
    cpu_level_nxt  = cpu_level_r;
    pick_lvl_nxt   = pick_lvl_r;
    status_nxt     = status_r;
    done_valid_nxt = done_valid_r;
    done_task_nxt  = done_task_r;
    done_time_nxt  = done_time_r;
    push_en        = 1'b0;
    push_lvl       = '0;
    push_id        = '0;
    rec_we         = 1'b0;
    rec_wa         = cpu_task_r;
    rec_wd         = rec_rd_r;

    // Latch the accepted word
    if (cmd.accept) begin
      mode_nxt       = in_mode;
      id_nxt         = in_task_id;
      burst_nxt      = in_burst_ms;
      now_nxt        = in_now_ms;
      status_nxt     = 1'b0;
      done_valid_nxt = 1'b0;
    end

    // Arrival: reject if queued or running, else requeue or create record
    if (cmd.arr) begin
      if (active_r[id_r]) begin
        status_nxt = 1'b1;
      end else begin
        active_nxt[id_r] = 1'b1;
        push_en          = 1'b1;
        push_id          = id_r;
        if (rec_valid_r[id_r]) begin
          push_lvl = task_level_r[id_r];
        end else begin
          rec_valid_nxt[id_r]  = 1'b1;
          task_level_nxt[id_r] = '0;
          rec_we               = 1'b1;
          rec_wa               = id_r;
          rec_wd.quantum_used  = '0;
          rec_wd.elapsed       = '0;
          rec_wd.burst         = burst_r;
        end
      end
    end

    // Tick: credit running task, finish or demote
    if (cmd.upd) begin
      rec_we              = 1'b1;
      rec_wa              = cpu_task_r;
      rec_wd.elapsed      = e_sat;
      rec_wd.quantum_used = upd_demote ? 16'd0 : q_sat;
      if (upd_done) begin
        rec_valid_nxt[cpu_task_r] = 1'b0;
        active_nxt[cpu_task_r]    = 1'b0;
        cpu_busy_nxt              = 1'b0;
        done_valid_nxt            = 1'b1;
        done_task_nxt             = cpu_task_r;
        done_time_nxt             = now_r;
      end else if (upd_demote) begin
        task_level_nxt[cpu_task_r] = demote_lvl;
        cpu_busy_nxt               = 1'b0;
        push_en                    = 1'b1;
        push_lvl                   = demote_lvl;
        push_id                    = cpu_task_r;
      end
    end

    // Fifo tail push, dropped when full
    if (push_ok) begin
      count_nxt[push_lvl] = count_r[push_lvl] + 1'b1;
    end

    // Remember which level the head read came from
    if (cmd.pick) begin
      pick_lvl_nxt = pick_lvl;
    end

    // Dispatch the head of the chosen level
    if (cmd.pop) begin
      cpu_busy_nxt              = 1'b1;
      cpu_task_nxt              = fifo_rd_r;
      cpu_level_nxt             = pick_lvl_r;
      task_level_nxt[fifo_rd_r] = pick_lvl_r;
      head_nxt[pick_lvl_r]      = head_r[pick_lvl_r] + 1'b1;
      count_nxt[pick_lvl_r]     = count_r[pick_lvl_r] - 1'b1;
    end
  end

  assign push_ok = push_en && (count_r[push_lvl] < CNT_W'(MAX_TASKS));
  assign fifo_wa = {push_lvl, head_r[push_lvl] + count_r[push_lvl][TASK_W-1:0]};

  // Result register
  always_comb begin
    out_valid_nxt    = out_valid_r;
    o_status_nxt     = o_status_r;
    o_done_valid_nxt = o_done_valid_r;
    o_done_task_nxt  = o_done_task_r;
    o_done_time_nxt  = o_done_time_r;
    o_run_valid_nxt  = o_run_valid_r;
    o_run_task_nxt   = o_run_task_r;
    o_run_level_nxt  = o_run_level_r;
    if (cmd.load_out) begin
      out_valid_nxt    = 1'b1;
      o_status_nxt     = status_r;
      o_done_valid_nxt = done_valid_r;
      o_done_task_nxt  = done_valid_r ? done_task_r : 4'd0;
      o_done_time_nxt  = done_valid_r ? done_time_r : 32'd0;
      o_run_valid_nxt  = cpu_busy_r;
      o_run_task_nxt   = cpu_busy_r ? cpu_task_r : 4'd0;
      o_run_level_nxt  = cpu_busy_r ? 2'(cpu_level_r) : 2'd0;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Record memory: read at accept for the running task, one write port
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rec_rd_r <= rec_mem[cpu_task_r];
    end
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
  end

  // Level fifo memory: tail write, head read
  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      fifo_rd_r <= fifo_mem[{pick_lvl, head_r[pick_lvl]}];
    end
    if (push_ok) begin
      fifo_mem[fifo_wa] <= push_id;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= '0;
      active_r    <= '0;
      head_r      <= '{default: '0};
      count_r     <= '{default: '0};
      cpu_busy_r  <= 1'b0;
      cpu_task_r  <= '0;
      cpu_level_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= rec_valid_nxt;
      active_r    <= active_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      cpu_busy_r  <= cpu_busy_nxt;
      cpu_task_r  <= cpu_task_nxt;
      cpu_level_r <= cpu_level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r         <= mode_nxt;
    id_r           <= id_nxt;
    burst_r        <= burst_nxt;
    now_r          <= now_nxt;
    task_level_r   <= task_level_nxt;
    pick_lvl_r     <= pick_lvl_nxt;
    status_r       <= status_nxt;
    done_valid_r   <= done_valid_nxt;
    done_task_r    <= done_task_nxt;
    done_time_r    <= done_time_nxt;
    o_status_r     <= o_status_nxt;
    o_done_valid_r <= o_done_valid_nxt;
    o_done_task_r  <= o_done_task_nxt;
    o_done_time_r  <= o_done_time_nxt;
    o_run_valid_r  <= o_run_valid_nxt;
    o_run_task_r   <= o_run_task_nxt;
    o_run_level_r  <= o_run_level_nxt;
  end

  // Status to controller
  always_comb begin
    sts.mode     = mode_r;
    sts.cpu_busy = cpu_busy_r;
    sts.frees    = upd_done || upd_demote;
    sts.nonempty = nonempty;
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = o_status_r;
  assign out_done_valid    = o_done_valid_r;
  assign out_done_task     = o_done_task_r;
  assign out_done_time_ms  = o_done_time_r;
  assign out_running_valid = o_run_valid_r;
  assign out_running_task  = o_run_task_r;
  assign out_running_level = o_run_level_r;

endmodule

/* design/multilevel_feedback_queue_scheduler_unit.sv */
// Three-level feedback queue scheduler. Each input word is an arrival
// (mode 0) or a tick (mode 1) and yields exactly one result word, in order.
// An arrival passes the idle (accept), arrival and output states. A tick
// passes idle and arrival, then the update state when a task holds the CPU,
// the pick state when the CPU is idle or the running task leaves, the pop
// state when a queued task is dispatched, and last the output state.
// The controller spends one state per step: the task record is read at
// acceptance and written back in the arrival or update state, and the level
// fifo memory head is read through a registered port in the pick state,
// before the pop state dispatches it. A new word is taken while a result
// still waits in the output register; a finished result waits in the output
// state while a stalled output word holds the result register. Registers sit at
// byte address 0 (quantum_ms) and 4 (tick_ms). Uses mfqs_pkg, mfqs_ctrl,
// mfqs_dp.
module multilevel_feedback_queue_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [3:0]  in_task_id,
  input  logic [31:0] in_burst_ms,
  input  logic [31:0] in_now_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic        out_done_valid,
  output logic [3:0]  out_done_task,
  output logic [31:0] out_done_time_ms,
  output logic        out_running_valid,
  output logic [3:0]  out_running_task,
  output logic [1:0]  out_running_level
);
  import mfqs_pkg::*;

  logic [15:0] quantum_r, quantum_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        cfg_wr;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    quantum_nxt = quantum_r;
    tick_nxt    = tick_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_QUANTUM: quantum_nxt = pwdata[15:0];
        REG_TICK:    tick_nxt    = pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RESET;
      tick_r    <= TICK_RESET;
    end else begin
      quantum_r <= quantum_nxt;
      tick_r    <= tick_nxt;
    end
  end

  // Register read back
  always_comb begin
    case (paddr[2])
      REG_QUANTUM: prdata = {16'd0, quantum_r};
      REG_TICK:    prdata = {16'd0, tick_r};
      default:     prdata = '0;
    endcase
  end

  mfqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfqs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .quantum_ms        (quantum_r),
    .tick_ms           (tick_r),
    .in_mode           (in_mode),
    .in_task_id        (in_task_id),
    .in_burst_ms       (in_burst_ms),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_done_valid    (out_done_valid),
    .out_done_task     (out_done_task),
    .out_done_time_ms  (out_done_time_ms),
    .out_running_valid (out_running_valid),
    .out_running_task  (out_running_task),
    .out_running_level (out_running_level)
  );

endmodule
